// ===== rtl/core/ssba_pkg.sv =====
package ssba_pkg;

	localparam int WORD_BITS = 32;
	localparam int BIT_W = 5;
	localparam int SLOT_W = 15;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [BIT_W-1:0] bit_idx_t;

	// keep only the lowest set bit
	function automatic word_t lowest_onehot(input word_t w);
		lowest_onehot = w & (~w + word_t'(1));
	endfunction

	// encode a one-hot word into its bit position
	function automatic bit_idx_t onehot_to_idx(input word_t oh);
		bit_idx_t idx;
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			idx = idx | (oh[i] ? bit_idx_t'(i) : '0);
		end
		onehot_to_idx = idx;
	endfunction

endpackage

// ===== rtl/core/ssba_ram.sv =====
module ssba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/swap_slot_bitmap_allocator.sv =====
// Load: written to the bitmap RAM at acceptance, no result.
// Allocate: the bitmap RAM is scanned one word per cycle from word 0; the lowest set
// bit found is cleared in the bitmap and its slot number is presented, else 0.
// Disabled allocate returns 0 without scanning.
// The next request is taken once the result is handed to the output register.
// Reset clears control state and swap_enabled; the bitmap is undefined until loaded.
module swap_slot_bitmap_allocator #(
	parameter int SLOT_COUNT = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [9:0]  word_index,
	input  logic [31:0] word_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] slot_number
);

	localparam int MAP_WORDS = (SLOT_COUNT + 31) / 32;
	localparam int AW = $clog2(MAP_WORDS);
	localparam int LAST_BITS = SLOT_COUNT % 32;
	localparam int SW = AW + ssba_pkg::BIT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic swap_enabled_q;

	logic [AW-1:0] addr_s1;
	logic [AW-1:0] rd_addr;
	ssba_pkg::word_t rd_data;

	logic [AW-1:0] wr_addr_q;
	ssba_pkg::word_t wr_data_q;
	logic do_write_q;
	logic [ssba_pkg::SLOT_W-1:0] res_q;

	logic out_valid_q;
	logic [ssba_pkg::SLOT_W-1:0] slot_q;

	logic accept;
	logic load_we;
	logic done_fire;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	ssba_pkg::word_t mem_wdata;

	ssba_pkg::word_t low_oh;
	ssba_pkg::bit_idx_t low_idx;
	logic is_last;
	logic beyond_end;
	logic [SW-1:0] found_slot;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign load_we = accept && (cmd == ssba_pkg::CMD_LOAD) && (32'(word_index) < MAP_WORDS);
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign mem_we = load_we || (done_fire && do_write_q);
	assign mem_waddr = load_we ? AW'(word_index) : wr_addr_q;
	assign mem_wdata = load_we ? word_value : wr_data_q;
	assign rd_addr = (state_q == S_SCAN) ? AW'(addr_s1 + AW'(1)) : '0;

	assign low_oh = ssba_pkg::lowest_onehot(rd_data);
	assign low_idx = ssba_pkg::onehot_to_idx(low_oh);
	assign is_last = (addr_s1 == AW'(MAP_WORDS - 1));
	assign beyond_end = (LAST_BITS != 0) && is_last &&
		(low_idx >= ssba_pkg::BIT_W'(LAST_BITS));
	assign found_slot = {addr_s1, low_idx};

	ssba_ram #(
		.WIDTH(ssba_pkg::WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_enabled_q <= 1'b0;
		end else if (cfg_wr_en) begin
			swap_enabled_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			do_write_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (cmd == ssba_pkg::CMD_ALLOC)) begin
						do_write_q <= 1'b0;
						state_q <= swap_enabled_q ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					if (rd_data != '0) begin
						do_write_q <= !beyond_end;
						state_q <= S_DONE;
					end else if (is_last) begin
						do_write_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (done_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// scan datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			addr_s1 <= '0;
			res_q <= '0;
		end else if (state_q == S_SCAN) begin
			addr_s1 <= rd_addr;
			if (rd_data != '0) begin
				wr_addr_q <= addr_s1;
				wr_data_q <= rd_data & ~low_oh;
				res_q <= beyond_end ? '0 : ssba_pkg::SLOT_W'(found_slot);
			end else begin
				res_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			slot_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign slot_number = slot_q;

endmodule
